>>> rtl/core/cecar_pkg.sv
`timescale 1ns / 1ps

package cecar_pkg;

  localparam int BYTE_W     = 8;
  localparam int LADDR_W    = 4;
  localparam int FLAGS_W    = 3;
  localparam int PADDR_W    = 16;
  localparam int DEVTYPE_W  = 4;
  localparam int NLEN_W     = 4;
  localparam int NAME_LO_W  = 64;
  localparam int NAME_HI_W  = 48;
  localparam int IDX_W      = 4;   // byte position within one reply, up to 16 bytes

  localparam int NAME_MAX   = 14;
  localparam int NAME_LO_CHARS = NAME_LO_W / BYTE_W;
  localparam int NAME_SLOTS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHYS_ADDR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_TYPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_HI   = 3'd6;

  localparam logic [LADDR_W-1:0]   RST_OWN_ADDR  = 4'hF;
  localparam logic [DEVTYPE_W-1:0] RST_DEV_TYPE  = 4'd4;

  localparam logic [LADDR_W-1:0]   ADDR_BCAST    = 4'hF;
  localparam int                   FLAG_ENABLE   = 0;
  localparam int                   FLAG_WAKE     = 2;

  // received opcodes
  localparam logic [BYTE_W-1:0] OP_GIVE_DECK_STATUS = 8'h1A;
  localparam logic [BYTE_W-1:0] OP_GIVE_OSD_NAME    = 8'h46;
  localparam logic [BYTE_W-1:0] OP_GIVE_PHYS_ADDR   = 8'h83;
  localparam logic [BYTE_W-1:0] OP_GIVE_VENDOR_ID   = 8'h8C;
  localparam logic [BYTE_W-1:0] OP_MENU_REQUEST     = 8'h8D;
  localparam logic [BYTE_W-1:0] OP_GIVE_POWER       = 8'h8F;
  localparam logic [BYTE_W-1:0] OP_GET_CEC_VERSION  = 8'h9F;

  // reply bytes
  localparam logic [BYTE_W-1:0] OP_DECK_STATUS      = 8'h1B;
  localparam logic [BYTE_W-1:0] DECK_STOPPED        = 8'h1A;
  localparam logic [BYTE_W-1:0] OP_SET_OSD_NAME     = 8'h47;
  localparam logic [BYTE_W-1:0] OP_REPORT_PHYS_ADDR = 8'h84;
  localparam logic [BYTE_W-1:0] OP_FEATURE_ABORT    = 8'h00;
  localparam logic [BYTE_W-1:0] ABORT_UNRECOGNIZED  = 8'h00;
  localparam logic [BYTE_W-1:0] OP_MENU_STATUS      = 8'h8E;
  localparam logic [BYTE_W-1:0] MENU_ACTIVE         = 8'h00;
  localparam logic [BYTE_W-1:0] OP_REPORT_POWER     = 8'h90;
  localparam logic [BYTE_W-1:0] POWER_ON            = 8'h00;
  localparam logic [BYTE_W-1:0] POWER_STANDBY       = 8'h02;
  localparam logic [BYTE_W-1:0] OP_CEC_VERSION      = 8'h9E;
  localparam logic [BYTE_W-1:0] CEC_VERSION_1_4     = 8'h05;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_DECK,
    KIND_OSD,
    KIND_PHYS,
    KIND_VENDOR,
    KIND_MENU,
    KIND_POWER,
    KIND_VERSION
  } reply_kind_e;

  typedef struct packed {
    reply_kind_e         kind;
    logic [BYTE_W-1:0]   head;      // first reply byte
    logic                powered;
    logic                wake;      // goes out on the last byte
    logic [IDX_W-1:0]    last_idx;
  } cmd_t;

  typedef struct packed {
    logic [PADDR_W-1:0]   phys_addr;
    logic [DEVTYPE_W-1:0] dev_type;
    logic [NAME_LO_W-1:0] name_lo;
    logic [NAME_HI_W-1:0] name_hi;
  } reply_cfg_t;

  typedef struct packed {
    logic [LADDR_W-1:0] own_addr;
    logic [FLAGS_W-1:0] flags;
    logic [NLEN_W-1:0]  name_len;
  } front_cfg_t;

endpackage

>>> rtl/core/cecar_if.sv
`timescale 1ns / 1ps

interface cecar_in_if;
  logic                          valid;
  logic                          ready;
  logic [cecar_pkg::BYTE_W-1:0]  frame_header;
  logic [cecar_pkg::BYTE_W-1:0]  frame_opcode;
  logic                          host_powered;

  modport source (output valid, frame_header, frame_opcode, host_powered, input ready);
  modport sink   (input valid, frame_header, frame_opcode, host_powered, output ready);
endinterface

interface cecar_out_if;
  logic                          valid;
  logic                          ready;
  logic [cecar_pkg::BYTE_W-1:0]  reply_byte;
  logic                          handled;
  logic                          last_byte;
  logic                          wake_host;

  modport source (output valid, reply_byte, handled, last_byte, wake_host, input ready);
  modport sink   (input valid, reply_byte, handled, last_byte, wake_host, output ready);
endinterface

>>> rtl/core/cecar_front.sv
`timescale 1ns / 1ps

module cecar_front (
  input  cecar_pkg::front_cfg_t        cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cecar_pkg::BYTE_W-1:0] frame_header_i,
  input  logic [cecar_pkg::BYTE_W-1:0] frame_opcode_i,
  input  logic                         host_powered_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output cecar_pkg::cmd_t              push_cmd_o
);

  logic [cecar_pkg::LADDR_W-1:0] initiator;
  logic [cecar_pkg::LADDR_W-1:0] dest;
  logic [cecar_pkg::NLEN_W-1:0]  name_len;
  logic                          respond;
  cecar_pkg::reply_kind_e        kind;
  logic [cecar_pkg::IDX_W-1:0]   last_idx;

  assign initiator = frame_header_i[cecar_pkg::BYTE_W-1:cecar_pkg::LADDR_W];
  assign dest      = frame_header_i[cecar_pkg::LADDR_W-1:0];

  assign respond = (cfg_i.own_addr != cecar_pkg::ADDR_BCAST) &&
                   cfg_i.flags[cecar_pkg::FLAG_ENABLE] &&
                   ((dest == cfg_i.own_addr) || (dest == cecar_pkg::ADDR_BCAST));

  // name length saturates
  assign name_len = (cfg_i.name_len > cecar_pkg::NLEN_W'(cecar_pkg::NAME_MAX)) ?
                    cecar_pkg::NLEN_W'(cecar_pkg::NAME_MAX) : cfg_i.name_len;

  always_comb begin
    kind     = cecar_pkg::KIND_NONE;
    last_idx = '0;
    if (respond) begin
      case (frame_opcode_i)
        cecar_pkg::OP_GIVE_DECK_STATUS: begin
          kind     = cecar_pkg::KIND_DECK;
          last_idx = 4'd2;
        end
        cecar_pkg::OP_GIVE_OSD_NAME: begin
          kind     = cecar_pkg::KIND_OSD;
          last_idx = cecar_pkg::IDX_W'(name_len) + 4'd1;
        end
        cecar_pkg::OP_GIVE_PHYS_ADDR: begin
          kind     = cecar_pkg::KIND_PHYS;
          last_idx = 4'd4;
        end
        cecar_pkg::OP_GIVE_VENDOR_ID: begin
          kind     = cecar_pkg::KIND_VENDOR;
          last_idx = 4'd3;
        end
        cecar_pkg::OP_MENU_REQUEST: begin
          kind     = cecar_pkg::KIND_MENU;
          last_idx = 4'd2;
        end
        cecar_pkg::OP_GIVE_POWER: begin
          kind     = cecar_pkg::KIND_POWER;
          last_idx = 4'd2;
        end
        cecar_pkg::OP_GET_CEC_VERSION: begin
          kind     = cecar_pkg::KIND_VERSION;
          last_idx = 4'd2;
        end
        default: begin
          kind     = cecar_pkg::KIND_NONE;
          last_idx = '0;
        end
      endcase
    end
  end

  always_comb begin
    push_cmd_o.kind     = kind;
    push_cmd_o.powered  = host_powered_i;
    push_cmd_o.last_idx = last_idx;
    push_cmd_o.wake     = (kind != cecar_pkg::KIND_NONE) && !host_powered_i &&
                          cfg_i.flags[cecar_pkg::FLAG_WAKE];
    case (kind)
      cecar_pkg::KIND_NONE: push_cmd_o.head = '0;
      cecar_pkg::KIND_PHYS: push_cmd_o.head = {cfg_i.own_addr, cecar_pkg::ADDR_BCAST};
      default:              push_cmd_o.head = {cfg_i.own_addr, initiator};
    endcase
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

endmodule

>>> rtl/core/cecar_queue.sv
`timescale 1ns / 1ps

module cecar_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  cecar_pkg::cmd_t push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output cecar_pkg::cmd_t pop_cmd_o
);

  cecar_pkg::cmd_t                entries_q [cecar_pkg::QUEUE_DEPTH];
  logic [cecar_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [cecar_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [cecar_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                           push, pop;

  localparam logic [cecar_pkg::QPTR_W-1:0] PtrLast =
    cecar_pkg::QPTR_W'(cecar_pkg::QUEUE_DEPTH - 1);

  assign push_ready_o = (count_q != cecar_pkg::QCNT_W'(cecar_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/core/cecar_back.sv
`timescale 1ns / 1ps

module cecar_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cecar_pkg::reply_cfg_t         cfg_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  cecar_pkg::cmd_t               cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cecar_pkg::BYTE_W-1:0]  reply_byte_o,
  output logic                          handled_o,
  output logic                          last_byte_o,
  output logic                          wake_host_o
);

  logic [cecar_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic                          valid_q, valid_d;
  logic [cecar_pkg::BYTE_W-1:0]  byte_q, byte_d;
  logic                          handled_q, last_q, wake_q;
  logic                          load, is_last;
  logic [cecar_pkg::IDX_W-1:0]   char_idx;
  logic [cecar_pkg::BYTE_W-1:0]  name_chars [cecar_pkg::NAME_SLOTS];

  always_comb begin
    for (int i = 0; i < cecar_pkg::NAME_SLOTS; i++) begin
      if (i < cecar_pkg::NAME_LO_CHARS) begin
        name_chars[i] = cfg_i.name_lo[i*cecar_pkg::BYTE_W +: cecar_pkg::BYTE_W];
      end else if (i < cecar_pkg::NAME_MAX) begin
        name_chars[i] =
          cfg_i.name_hi[(i-cecar_pkg::NAME_LO_CHARS)*cecar_pkg::BYTE_W +: cecar_pkg::BYTE_W];
      end else begin
        name_chars[i] = '0;
      end
    end
  end

  // name characters start after header and opcode
  assign char_idx = idx_q - 4'd2;

  always_comb begin
    byte_d = '0;
    if (idx_q == '0) begin
      byte_d = cmd_i.head;
    end else begin
      case (cmd_i.kind)
        cecar_pkg::KIND_DECK:
          byte_d = (idx_q == 4'd1) ? cecar_pkg::OP_DECK_STATUS : cecar_pkg::DECK_STOPPED;
        cecar_pkg::KIND_OSD:
          byte_d = (idx_q == 4'd1) ? cecar_pkg::OP_SET_OSD_NAME : name_chars[char_idx];
        cecar_pkg::KIND_PHYS: begin
          case (idx_q)
            4'd1:    byte_d = cecar_pkg::OP_REPORT_PHYS_ADDR;
            4'd2:    byte_d = cfg_i.phys_addr[15:8];
            4'd3:    byte_d = cfg_i.phys_addr[7:0];
            default: byte_d = cecar_pkg::BYTE_W'(cfg_i.dev_type);
          endcase
        end
        cecar_pkg::KIND_VENDOR: begin
          case (idx_q)
            4'd1:    byte_d = cecar_pkg::OP_FEATURE_ABORT;
            4'd2:    byte_d = cecar_pkg::OP_GIVE_VENDOR_ID;
            default: byte_d = cecar_pkg::ABORT_UNRECOGNIZED;
          endcase
        end
        cecar_pkg::KIND_MENU:
          byte_d = (idx_q == 4'd1) ? cecar_pkg::OP_MENU_STATUS : cecar_pkg::MENU_ACTIVE;
        cecar_pkg::KIND_POWER:
          byte_d = (idx_q == 4'd1) ? cecar_pkg::OP_REPORT_POWER :
                   (cmd_i.powered ? cecar_pkg::POWER_ON : cecar_pkg::POWER_STANDBY);
        cecar_pkg::KIND_VERSION:
          byte_d = (idx_q == 4'd1) ? cecar_pkg::OP_CEC_VERSION : cecar_pkg::CEC_VERSION_1_4;
        default:
          byte_d = '0;
      endcase
    end
  end

  assign is_last     = (idx_q == cmd_i.last_idx);
  assign load        = cmd_valid_i && (!valid_q || out_ready_i);
  assign cmd_ready_o = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= byte_d;
      handled_q <= (cmd_i.kind != cecar_pkg::KIND_NONE);
      last_q    <= is_last;
      wake_q    <= is_last && cmd_i.wake;
    end
  end

  assign out_valid_o  = valid_q;
  assign reply_byte_o = byte_q;
  assign handled_o    = handled_q;
  assign last_byte_o  = last_q;
  assign wake_host_o  = wake_q;

endmodule

>>> rtl/core/cec_auto_responder_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat payload                                       Handshake
// in_if     in   frame_header[7:0], frame_opcode[7:0], host_powered  valid/ready
// out_if    out  reply_byte[7:0], handled, last_byte, wake_host      valid/ready
// cfg       in   cfg_idx_i[2:0], cfg_wdata_i[63:0]                   cfg_we_i, no wait
//
// One reply byte per cycle while out_if is ready: a frame's reply is 1 to 16
// bytes (header, opcode, operands), set by the back-end byte sequencer.
// The first reply beat is registered in the queue, then in the output register.
// A 2-entry command queue lets frames be taken while a reply is still draining.
// Reset (async, active low) clears control state and loads register defaults.
// Output stall holds the output register; input stalls only when the queue is full.

module cec_auto_responder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cecar_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cecar_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  cecar_in_if.sink                          in_if,
  cecar_out_if.source                       out_if
);

  // configuration registers
  logic [cecar_pkg::LADDR_W-1:0]   own_addr_q;
  logic [cecar_pkg::FLAGS_W-1:0]   flags_q;
  logic [cecar_pkg::PADDR_W-1:0]   phys_addr_q;
  logic [cecar_pkg::DEVTYPE_W-1:0] dev_type_q;
  logic [cecar_pkg::NLEN_W-1:0]    name_len_q;
  logic [cecar_pkg::NAME_LO_W-1:0] name_lo_q;
  logic [cecar_pkg::NAME_HI_W-1:0] name_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= cecar_pkg::RST_OWN_ADDR;
      flags_q     <= '0;
      phys_addr_q <= '0;
      dev_type_q  <= cecar_pkg::RST_DEV_TYPE;
      name_len_q  <= '0;
      name_lo_q   <= '0;
      name_hi_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cecar_pkg::REG_OWN_ADDR:  own_addr_q  <= cfg_wdata_i[cecar_pkg::LADDR_W-1:0];
        cecar_pkg::REG_CTRL:      flags_q     <= cfg_wdata_i[cecar_pkg::FLAGS_W-1:0];
        cecar_pkg::REG_PHYS_ADDR: phys_addr_q <= cfg_wdata_i[cecar_pkg::PADDR_W-1:0];
        cecar_pkg::REG_DEV_TYPE:  dev_type_q  <= cfg_wdata_i[cecar_pkg::DEVTYPE_W-1:0];
        cecar_pkg::REG_NAME_LEN:  name_len_q  <= cfg_wdata_i[cecar_pkg::NLEN_W-1:0];
        cecar_pkg::REG_NAME_LO:   name_lo_q   <= cfg_wdata_i[cecar_pkg::NAME_LO_W-1:0];
        cecar_pkg::REG_NAME_HI:   name_hi_q   <= cfg_wdata_i[cecar_pkg::NAME_HI_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  cecar_pkg::front_cfg_t front_cfg;
  cecar_pkg::reply_cfg_t reply_cfg;

  assign front_cfg.own_addr  = own_addr_q;
  assign front_cfg.flags     = flags_q;
  assign front_cfg.name_len  = name_len_q;
  assign reply_cfg.phys_addr = phys_addr_q;
  assign reply_cfg.dev_type  = dev_type_q;
  assign reply_cfg.name_lo   = name_lo_q;
  assign reply_cfg.name_hi   = name_hi_q;

  logic            push_valid, push_ready;
  cecar_pkg::cmd_t push_cmd;
  logic            pop_valid, pop_ready;
  cecar_pkg::cmd_t pop_cmd;

  // front: address filter and opcode decode into a reply command
  cecar_front u_front (
    .cfg_i          (front_cfg),
    .in_valid_i     (in_if.valid),
    .in_ready_o     (in_if.ready),
    .frame_header_i (in_if.frame_header),
    .frame_opcode_i (in_if.frame_opcode),
    .host_powered_i (in_if.host_powered),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_cmd_o     (push_cmd)
  );

  cecar_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // back: walks each command byte by byte into the output register
  cecar_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (reply_cfg),
    .cmd_valid_i  (pop_valid),
    .cmd_ready_o  (pop_ready),
    .cmd_i        (pop_cmd),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .reply_byte_o (out_if.reply_byte),
    .handled_o    (out_if.handled),
    .last_byte_o  (out_if.last_byte),
    .wake_host_o  (out_if.wake_host)
  );

endmodule
